/* sv/gaussian_polar_transform_core_defines.svh */
// Assertion macros shared by the Gaussian polar transform RTL.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef GAUSSIAN_POLAR_TRANSFORM_CORE_DEFINES_SVH
`define GAUSSIAN_POLAR_TRANSFORM_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset only.
`define GPT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gpt assertion failed");

// Next-cycle implication, checked out of reset only.
`define GPT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gpt assertion failed");

`endif

/* sv/gpt_pkg.sv */
// Types, constants and state encoding for the Gaussian polar transform core.
// No dependencies; used by every module of the block.
package gpt_pkg;

    localparam int UNIFORM_BITS = 24;
    localparam int ABS_W        = UNIFORM_BITS;
    localparam int SQ_W         = 2 * UNIFORM_BITS - 1;
    localparam int SUM_W        = 2 * UNIFORM_BITS;
    localparam int F_BITS       = 2 * UNIFORM_BITS - 2;
    localparam int P_W          = 6;
    localparam int K_W          = 5;

    localparam logic [ABS_W-1:0] HALF_U         = ABS_W'(1) << (UNIFORM_BITS - 1);
    localparam logic [SUM_W-1:0] UNIT_RADIUS_SQ = SUM_W'(1) << F_BITS;
    localparam logic [6:0]       NORM_K_BASE    = 7'd61;
    localparam logic [24:0]      TWO_LN2_Q24    = 25'd23258160;
    localparam logic [30:0]      STD_DEV_RESET  = 31'd65536;

    localparam logic REG_MEAN    = 1'b0;
    localparam logic REG_STD_DEV = 1'b1;

    typedef struct packed {
        logic [UNIFORM_BITS-1:0] uniform_a;
        logic [UNIFORM_BITS-1:0] uniform_b;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               last_of_pair;
    } out_item_t;

    // Classified pair waiting for the back end.
    typedef struct packed {
        logic [SQ_W-1:0]  s;
        logic [P_W-1:0]   p;
        logic [K_W-1:0]   k;
        logic             neg1;
        logic             neg2;
        logic [ABS_W-1:0] a1;
        logic [ABS_W-1:0] a2;
    } q_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOG,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SQRT_G,
        ST_SQRT_R,
        ST_DIV,
        ST_MUL_X,
        ST_MUL_T,
        ST_OUT
    } back_state_t;

endpackage

/* sv/gaussian_polar_transform_core.sv */
// Gaussian sampler by the polar method: input pairs of uniforms, output
// saturated Q16.16 normal variates.
// Usage:
//   Input channel in_valid/in_stall/in_item carries one uniform pair per beat.
//   Output channel out_valid/out_stall/out_item carries one variate per beat;
//   an accepted pair gives two beats, the second with last_of_pair set.
//   A pair outside the unit circle or at zero radius gives no beat.
//   cfg_we/cfg_index/cfg_data write mean (index 0) or std_dev (index 1);
//   write only while the block is idle.
// Timing:
//   The front end takes a pair every cycle while in_stall is low and passes
//   accepted pairs into a two-entry queue. The back end works on one accepted
//   pair at a time: 32 log squaring steps, two 32-step square roots on one
//   shared unit and two 31-step divisions, so this sets the sustained rate.
// Reset:
//   rst_n clears the pipeline and queue, sets mean to 0 and std_dev to 1.0.
//   While out_stall holds, the output beat is held and the back end waits;
//   the queue then fills and in_stall rises.
module gaussian_polar_transform_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  gpt_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output gpt_pkg::out_item_t out_item,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data
);
    import gpt_pkg::*;

    logic     push;
    q_entry_t push_data;
    logic     full;
    logic     pop;
    q_entry_t pop_data;
    logic     empty;

    gpt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    gpt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    gpt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .pop       (pop),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

/* sv/gpt_front.sv */
// Front end: takes uniform pairs, squares the offsets, rejects pairs outside
// the unit circle or at zero radius. Depends on gpt_pkg.
module gpt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  gpt_pkg::in_item_t in_item,
    output logic              push,
    output gpt_pkg::q_entry_t push_data,
    input  logic              full
);
    import gpt_pkg::*;

    logic             f_valid_reg;
    logic [SQ_W-1:0]  f_sq1_reg;
    logic [SQ_W-1:0]  f_sq2_reg;
    logic [ABS_W-1:0] f_a1_reg;
    logic [ABS_W-1:0] f_a2_reg;
    logic             f_n1_reg;
    logic             f_n2_reg;

    logic             n1;
    logic             n2;
    logic [ABS_W-1:0] a1;
    logic [ABS_W-1:0] a2;
    logic [2*ABS_W-1:0] prod1;
    logic [2*ABS_W-1:0] prod2;
    logic [SUM_W-1:0] sum;
    logic [P_W-1:0]   msb;
    logic [6:0]       kk;
    logic             reject;
    logic             adv;

    assign n1    = ~in_item.uniform_a[UNIFORM_BITS-1];
    assign n2    = ~in_item.uniform_b[UNIFORM_BITS-1];
    assign a1    = n1 ? (HALF_U - in_item.uniform_a) : (in_item.uniform_a - HALF_U);
    assign a2    = n2 ? (HALF_U - in_item.uniform_b) : (in_item.uniform_b - HALF_U);
    assign prod1 = a1 * a1;
    assign prod2 = a2 * a2;

    assign sum    = {1'b0, f_sq1_reg} + {1'b0, f_sq2_reg};
    assign reject = (sum == '0) || (sum > UNIT_RADIUS_SQ);

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < SUM_W; i++)
        begin
            if (sum[i])
            begin
                msb = P_W'(i);
            end
        end
    end

    // shift count that brings the radius square to at least 2^60
    assign kk = NORM_K_BASE - {1'b0, msb};

    assign adv      = !f_valid_reg || reject || !full;
    assign in_stall = f_valid_reg && !adv;
    assign push     = f_valid_reg && !reject && !full;

    always_comb
    begin
        push_data.s    = sum[SQ_W-1:0];
        push_data.p    = msb;
        push_data.k    = kk[K_W:1];
        push_data.neg1 = f_n1_reg;
        push_data.neg2 = f_n2_reg;
        push_data.a1   = f_a1_reg;
        push_data.a2   = f_a2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            f_sq1_reg <= prod1[SQ_W-1:0];
            f_sq2_reg <= prod2[SQ_W-1:0];
            f_a1_reg  <= a1;
            f_a2_reg  <= a2;
            f_n1_reg  <= n1;
            f_n2_reg  <= n2;
        end
    end

endmodule

/* sv/gpt_queue.sv */
// Two-entry queue between the classifying front end and the back end.
// Depends on gpt_pkg and the shared assertion macros.
`include "gaussian_polar_transform_core_defines.svh"
module gpt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  gpt_pkg::q_entry_t push_data,
    output logic              full,
    input  logic              pop,
    output gpt_pkg::q_entry_t pop_data,
    output logic              empty
);
    import gpt_pkg::*;

    q_entry_t   mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    `GPT_ASSERT_IMP(a_no_overflow, push, count_reg != 2'd2)
    `GPT_ASSERT_IMP(a_no_underflow, pop, count_reg != 2'd0)
    `GPT_ASSERT_NXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 2'd1)

endmodule

/* sv/gpt_back.sv */
// Back end: log, square roots, division and scaling for one pair at a time,
// plus the config registers and the output register. Depends on gpt_pkg and the shared assertion macros.
`include "gaussian_polar_transform_core_defines.svh"
module gpt_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               empty,
    output logic               pop,
    input  gpt_pkg::q_entry_t  pop_data,
    output logic               out_valid,
    input  logic               out_stall,
    output gpt_pkg::out_item_t out_item
);
    import gpt_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    logic signed [31:0] mean_reg;
    logic [30:0]        std_dev_reg;

    logic [SQ_W-1:0]  s_reg;
    logic [P_W-1:0]   p_reg;
    logic [K_W-1:0]   k_reg;
    logic             n1_reg;
    logic             n2_reg;
    logic [ABS_W-1:0] a1_reg;
    logic [ABS_W-1:0] a2_reg;
    logic             which_reg;
    logic [4:0]       cnt_reg;

    logic [31:0] m_reg;
    logic [31:0] frac_reg;
    logic [63:0] lprod_reg;
    logic [63:0] x_reg;
    logic [62:0] res_reg;
    logic [62:0] bit_reg;
    logic [31:0] g_reg;
    logic [31:0] r_reg;
    logic [32:0] rem_reg;
    logic [30:0] q_reg;
    logic [63:0] prod_reg;

    logic              out_valid_reg;
    out_item_t         out_reg;

    logic [63:0] s64_in;
    logic [P_W-1:0] sh_r;
    logic [P_W-1:0] sh_l;
    logic [63:0] m0_wide;
    logic [63:0] sq64;
    logic [32:0] m1;
    logic [37:0] lval;
    logic [43:0] lo_prod;
    logic [43:0] hi_prod;
    logic [63:0] lsum;
    logic [63:0] trial;
    logic        sq_ge;
    logic [62:0] res_step;
    logic [63:0] sn;
    logic [63:0] mag1_wide;
    logic [63:0] mag2_wide;
    logic [33:0] dt;
    logic        d_ge;
    logic [33:0] d_rem;
    logic [62:0] qg;
    logic [63:0] xr_sum;
    logic [29:0] x24;
    logic [60:0] tprod;
    logic [63:0] t_sum;
    logic [39:0] t_mag;
    logic signed [41:0] v;
    logic signed [41:0] total;
    logic signed [31:0] sat;
    logic        neg_sel;
    logic        load;

    // ---------------- datapath combinational terms ----------------
    assign s64_in  = {{(64-SQ_W){1'b0}}, pop_data.s};
    assign sh_r    = pop_data.p - P_W'(31);
    assign sh_l    = P_W'(31) - pop_data.p;
    assign m0_wide = (pop_data.p >= P_W'(31)) ? (s64_in >> sh_r) : (s64_in << sh_l);

    assign sq64 = m_reg * m_reg;
    assign m1   = sq64[63:31];

    assign lval    = {P_W'(F_BITS) - p_reg, 32'd0} - {6'd0, frac_reg};
    assign lo_prod = lval[18:0] * TWO_LN2_Q24;
    assign hi_prod = lval[37:19] * TWO_LN2_Q24;
    assign lsum    = lprod_reg + ({20'd0, hi_prod} << 19);

    assign trial    = {1'b0, res_reg} + {1'b0, bit_reg};
    assign sq_ge    = (x_reg >= trial);
    assign res_step = sq_ge ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);

    assign sn        = {{(64-SQ_W){1'b0}}, s_reg} << {k_reg, 1'b0};
    assign mag1_wide = {{(64-ABS_W){1'b0}}, a1_reg} << k_reg;
    assign mag2_wide = {{(64-ABS_W){1'b0}}, a2_reg} << k_reg;

    // first quotient step compares without shifting
    assign dt    = (cnt_reg == 5'd0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign d_ge  = (dt >= {2'd0, r_reg});
    assign d_rem = d_ge ? (dt - {2'd0, r_reg}) : dt;

    assign qg     = q_reg * g_reg;
    assign xr_sum = prod_reg + (64'd1 << 33);
    assign x24    = xr_sum[63:34];
    assign tprod  = std_dev_reg * x24;

    assign t_sum   = prod_reg + (64'd1 << 23);
    assign t_mag   = t_sum[63:24];
    assign neg_sel = which_reg ? n2_reg : n1_reg;
    assign v       = neg_sel ? -$signed({2'b00, t_mag}) : $signed({2'b00, t_mag});
    assign total   = 42'(mean_reg) + v;

    always_comb
    begin
        if (total > 42'sd2147483647)
        begin
            sat = 32'sh7fffffff;
        end
        else if (total < -42'sd2147483648)
        begin
            sat = 32'sh80000000;
        end
        else
        begin
            sat = total[31:0];
        end
    end

    assign load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);
    assign pop  = (state_reg == ST_IDLE) && !empty;

    // ---------------- state machine ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    state_next = ST_LOG;
                end
            end
            ST_LOG:
            begin
                if (cnt_reg == 5'd31)
                begin
                    state_next = ST_MUL_LO;
                end
            end
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_SQRT_G;
            ST_SQRT_G:
            begin
                if (cnt_reg == 5'd31)
                begin
                    state_next = ST_SQRT_R;
                end
            end
            ST_SQRT_R:
            begin
                if (cnt_reg == 5'd31)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == 5'd30)
                begin
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X: state_next = ST_MUL_T;
            ST_MUL_T: state_next = ST_OUT;
            ST_OUT:
            begin
                if (load)
                begin
                    state_next = which_reg ? ST_IDLE : ST_DIV;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- control counters and flags ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= 5'd0;
            which_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            mean_reg      <= 32'sd0;
            std_dev_reg   <= STD_DEV_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MEAN:    mean_reg    <= cfg_data;
                    REG_STD_DEV: std_dev_reg <= cfg_data[30:0];
                    default:     ;
                endcase
            end

            if (state_reg != state_next)
            begin
                cnt_reg <= 5'd0;
            end
            else if (state_reg == ST_LOG || state_reg == ST_SQRT_G ||
                     state_reg == ST_SQRT_R || state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg + 5'd1;
            end

            if (pop)
            begin
                which_reg <= 1'b0;
            end
            else if (load)
            begin
                which_reg <= 1'b1;
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    s_reg    <= pop_data.s;
                    p_reg    <= pop_data.p;
                    k_reg    <= pop_data.k;
                    n1_reg   <= pop_data.neg1;
                    n2_reg   <= pop_data.neg2;
                    a1_reg   <= pop_data.a1;
                    a2_reg   <= pop_data.a2;
                    m_reg    <= m0_wide[31:0];
                    frac_reg <= 32'd0;
                end
            end
            ST_LOG:
            begin
                // square the mantissa, renormalize and shift in one fraction bit
                if (m1[32])
                begin
                    m_reg <= m1[32:1];
                end
                else
                begin
                    m_reg <= m1[31:0];
                end
                frac_reg <= {frac_reg[30:0], m1[32]};
            end
            ST_MUL_LO:
            begin
                lprod_reg <= {20'd0, lo_prod};
            end
            ST_MUL_HI:
            begin
                x_reg   <= lsum;
                res_reg <= 63'd0;
                bit_reg <= 63'd1 << 62;
            end
            ST_SQRT_G, ST_SQRT_R:
            begin
                if (cnt_reg == 5'd31)
                begin
                    if (state_reg == ST_SQRT_G)
                    begin
                        g_reg   <= res_step[31:0];
                        x_reg   <= sn;
                        res_reg <= 63'd0;
                        bit_reg <= 63'd1 << 62;
                    end
                    else
                    begin
                        r_reg   <= res_step[31:0];
                        rem_reg <= {1'b0, mag1_wide[31:0]};
                        q_reg   <= 31'd0;
                    end
                end
                else
                begin
                    if (sq_ge)
                    begin
                        x_reg <= x_reg - trial;
                    end
                    res_reg <= res_step;
                    bit_reg <= bit_reg >> 2;
                end
            end
            ST_DIV:
            begin
                rem_reg <= d_rem[32:0];
                q_reg   <= {q_reg[29:0], d_ge};
            end
            ST_MUL_X:
            begin
                prod_reg <= {1'b0, qg};
            end
            ST_MUL_T:
            begin
                prod_reg <= {3'd0, tprod};
            end
            ST_OUT:
            begin
                if (load)
                begin
                    out_reg.sample       <= sat;
                    out_reg.last_of_pair <= which_reg;
                    if (!which_reg)
                    begin
                        rem_reg <= {1'b0, mag2_wide[31:0]};
                        q_reg   <= 31'd0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    `GPT_ASSERT_IMP(a_pop_from_idle, pop, state_reg == ST_IDLE && !empty)
    `GPT_ASSERT_NXT(a_pair_done, load && which_reg, state_reg == ST_IDLE)
    `GPT_ASSERT_NXT(a_last_flag, load, out_item.last_of_pair == $past(which_reg))

endmodule
